/* rtl/scpr_pkg.sv */
// shared constants and types for the second-chance page replacement block
package scpr_pkg;

  localparam int ADDR_W         = 32;
  localparam int PAGE_W         = 20;
  localparam int FAULT_W        = 32;
  localparam int FRAMES_W       = 7;
  localparam int OFFSET_W       = 5;
  localparam int CFG_W          = 7;
  localparam int CFG_IDX_W      = 1;
  localparam int MAX_FRAMES_DEF = 64;

  localparam logic [FRAMES_W-1:0] RESET_FRAMES = 7'd16;
  localparam logic [OFFSET_W-1:0] RESET_OFFSET = 5'd12;
  localparam logic [OFFSET_W-1:0] MIN_OFFSET   = 5'd12;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS   = 1'b1;

  // command broadcast from the controller to every frame cell
  typedef struct packed {
    logic compare;
    logic set_ref;
    logic clear_ref;
    logic load;
  } scpr_cmd_t;

endpackage

/* rtl/scpr_cell.sv */
// one frame cell: page tag, valid flag, reference bit and tag comparator
module scpr_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [scpr_pkg::PAGE_W-1:0] page,
  input  scpr_pkg::scpr_cmd_t       cmd,
  input  logic                      sel,
  input  logic                      active,
  output logic                      match,
  output logic                      ref_bit
);
  import scpr_pkg::*;

  logic [PAGE_W-1:0] tag;
  logic              valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      ref_bit <= 1'b0;
    end else if (sel && cmd.load) begin
      valid   <= 1'b1;
      ref_bit <= 1'b0;
    end else if (sel && cmd.set_ref) begin
      ref_bit <= 1'b1;
    end else if (sel && cmd.clear_ref) begin
      ref_bit <= 1'b0;
    end
  end

  // tag has no reset, it is only looked at while valid is set
  always_ff @(posedge clk) begin
    if (sel && cmd.load) begin
      tag <= page;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      match <= valid && active && (tag == page);
    end
  end

endmodule

/* rtl/second_chance_page_replacement_top.sv */
// top level: clock (second-chance) page replacement over a row of frame cells
//
//  channel   direction  handshake            payload
//  in        input      in_valid / in_stall  address
//  out       output     out_valid/out_stall  hit, frame_index, fault_total
//  cfg       input      cfg_write            cfg_index, cfg_data
//
// a hit goes from accept to a compare in every cell, then a priority pick of the
// lowest matching frame, whose result is loaded into the output register
// a miss goes on from the pick to a sweep that clears each set reference bit the
// hand passes over, as the hand visits one frame per cycle
// one word in flight at a time; in_stall is high while reset is held and from
// accept until the result is loaded into the output register, and no new word
// is taken while it waits
// a stalled output holds the finishing step until the register frees up
// reset clears all valid and reference bits, the hand and the fault count
module second_chance_page_replacement_top #(
  parameter int MAX_FRAMES = scpr_pkg::MAX_FRAMES_DEF,
  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_write,
  input  logic [scpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scpr_pkg::CFG_W-1:0]    cfg_data,
  // input word
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [scpr_pkg::ADDR_W-1:0]   address,
  // result word
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hit,
  output logic [IDX_W-1:0]              frame_index,
  output logic [scpr_pkg::FAULT_W-1:0]  fault_total
);
  import scpr_pkg::*;

  // width wide enough for both the frame count register and MAX_FRAMES
  localparam int CNT_W0 = $clog2(MAX_FRAMES + 1);
  localparam int CNT_W  = (CNT_W0 > FRAMES_W) ? CNT_W0 : FRAMES_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAMES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_PICK,
    S_SWEEP
  } state_t;

  state_t state;

  // configuration registers
  logic [FRAMES_W-1:0] frames_in_use;
  logic [OFFSET_W-1:0] offset_bits;

  // working registers
  logic [PAGE_W-1:0]   page;
  logic [IDX_W-1:0]    hand;
  logic [IDX_W-1:0]    pos;
  logic [FAULT_W-1:0]  fault_counter;

  // cell row signals
  scpr_cmd_t           cmd;
  logic [MAX_FRAMES-1:0] sel_vec;
  logic [MAX_FRAMES-1:0] active_vec;
  logic [MAX_FRAMES-1:0] match_vec;
  logic [MAX_FRAMES-1:0] ref_vec;

  // combinational helpers
  logic [CNT_W-1:0]    frames_ext;
  logic [CNT_W-1:0]    n_eff;
  logic [OFFSET_W-1:0] shamt;
  logic [ADDR_W-1:0]   shifted;
  logic [PAGE_W-1:0]   page_c;
  logic                any_hit;
  logic [IDX_W-1:0]    hit_idx;
  logic [IDX_W-1:0]    target;
  logic [CNT_W-1:0]    pos_inc;
  logic [IDX_W-1:0]    pos_wrap;
  logic                hand_ok;
  logic                out_free;
  logic                pos_ref;

  // effective frame count: zero acts as one, above the row size clamps
  assign frames_ext = CNT_W'(frames_in_use);
  always_comb begin
    if (frames_ext == '0) begin
      n_eff = CNT_W'(1);
    end else if (frames_ext > MAX_CNT) begin
      n_eff = MAX_CNT;
    end else begin
      n_eff = frames_ext;
    end
  end

  // page number: address shifted by the offset width, never less than the minimum
  assign shamt   = (offset_bits < MIN_OFFSET) ? MIN_OFFSET : offset_bits;
  assign shifted = address >> shamt;
  assign page_c  = shifted[PAGE_W-1:0];

  // lowest matching frame wins when a page sits in two frames
  always_comb begin
    any_hit = 1'b0;
    hit_idx = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        any_hit = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  // hand stepping with wrap at the frame count
  assign pos_inc  = CNT_W'(pos) + CNT_W'(1);
  assign pos_wrap = (pos_inc >= n_eff) ? '0 : pos_inc[IDX_W-1:0];
  assign hand_ok  = (CNT_W'(hand) < n_eff);
  assign pos_ref  = ref_vec[pos];

  assign out_free = !out_valid || !out_stall;
  // no word is taken while reset is held
  assign in_stall = rst || (state != S_IDLE);

  // cell commands
  assign target = (state == S_PICK) ? hit_idx : pos;
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
      end
      S_CMP: begin
        cmd.compare = 1'b1;
      end
      S_PICK: begin
        cmd.set_ref = any_hit && out_free;
      end
      S_SWEEP: begin
        cmd.clear_ref = pos_ref;
        cmd.load      = !pos_ref && out_free;
      end
      default: begin
      end
    endcase
  end

  // the row of frame cells
  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    assign sel_vec[g]    = (target == IDX_W'(g));
    assign active_vec[g] = (CNT_W'(g) < n_eff);

    scpr_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .page    (page),
      .cmd     (cmd),
      .sel     (sel_vec[g]),
      .active  (active_vec[g]),
      .match   (match_vec[g]),
      .ref_bit (ref_vec[g])
    );
  end

  // page register, sweep position and output payload carry no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      hand          <= '0;
      fault_counter <= '0;
      frames_in_use <= RESET_FRAMES;
      offset_bits   <= RESET_OFFSET;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_FRAMES_IN_USE: frames_in_use <= cfg_data[FRAMES_W-1:0];
          REG_OFFSET_BITS:   offset_bits   <= cfg_data[OFFSET_W-1:0];
          default: begin
          end
        endcase
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            page  <= page_c;
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_PICK;
        end
        S_PICK: begin
          if (any_hit) begin
            if (out_free) begin
              out_valid   <= 1'b1;
              hit         <= 1'b1;
              frame_index <= hit_idx;
              fault_total <= fault_counter;
              state       <= S_IDLE;
            end
          end else begin
            // fault: count it (saturating) and start the hand sweep
            if (fault_counter != '1) begin
              fault_counter <= fault_counter + FAULT_W'(1);
            end
            pos   <= hand_ok ? hand : '0;
            state <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (pos_ref) begin
            // second chance: bit cleared by the cell, move on
            pos <= pos_wrap;
          end else if (out_free) begin
            out_valid   <= 1'b1;
            hit         <= 1'b0;
            frame_index <= pos;
            fault_total <= fault_counter;
            hand        <= pos_wrap;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench for the second-chance page replacement block

module testbench;
  import scpr_pkg::*;

  localparam int FRAME_W     = 6;
  localparam int HOLD_CYCLES = 150;
  localparam int LIMIT       = 400000;

  // expected result word, oldest at the front of the queue
  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
    logic [FAULT_W-1:0] faults;
  } access_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FRAMES_IN_USE;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [ADDR_W-1:0]    address = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 hit;
  logic [FRAME_W-1:0]   frame_index;
  logic [FAULT_W-1:0]   fault_total;

  second_chance_page_replacement_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .address(address),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .hit(hit),
    .frame_index(frame_index),
    .fault_total(fault_total)
  );

  // page table model: tags, valid and reference bits, hand and fault count
  logic [PAGE_W-1:0]   model_tag [MAX_FRAMES_DEF];
  bit                  model_valid [MAX_FRAMES_DEF];
  bit                  model_ref [MAX_FRAMES_DEF];
  int unsigned         model_hand;
  logic [FAULT_W-1:0]  model_faults;
  logic [FRAMES_W-1:0] cfg_frames;
  logic [OFFSET_W-1:0] cfg_offset;

  access_result_t    expected_results [$];
  logic [PAGE_W-1:0] page_pool [$];

  int unsigned cycle_count = 0;
  int unsigned failures = 0;
  int unsigned hits_seen = 0;
  int unsigned faults_seen = 0;
  int unsigned reg_writes = 0;

  // traffic shaping shared by the sender and the receiver
  logic calm = 1'b0;
  logic hold_off = 1'b0;
  logic hold_done = 1'b0;
  int unsigned hold_count = 0;

  always #1 clk = ~clk;

  // watchdog: a correct run ends far below this
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_count,
               expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver side: random stalls, a calm stretch, and one long hold-off
  // counted here so the block fills up and pushes back on the sender
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_off && !hold_done) begin
      out_stall <= 1'b1;
      hold_count <= hold_count + 1;
      if (hold_count == HOLD_CYCLES - 1) hold_done <= 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 29);
    end
  end

  // frame count as the block sees it: zero acts as one, too many clip to the max
  function automatic int unsigned active_frame_count();
    if (cfg_frames == 0) return 1;
    else if (cfg_frames > MAX_FRAMES_DEF) return MAX_FRAMES_DEF;
    else return int'(cfg_frames);
  endfunction

  // offsets below the minimum act as the minimum, larger ones shift as given
  function automatic int unsigned page_shift();
    return (cfg_offset < MIN_OFFSET) ? int'(MIN_OFFSET) : int'(cfg_offset);
  endfunction

  function automatic logic [PAGE_W-1:0] page_of_address(input logic [ADDR_W-1:0] addr);
    return PAGE_W'(addr >> page_shift());
  endfunction

  // builds an address in the given page with random offset bits
  function automatic logic [ADDR_W-1:0] address_for_page(input logic [PAGE_W-1:0] pg);
    int unsigned sh;
    logic [ADDR_W-1:0] low_mask;
    sh = page_shift();
    low_mask = (ADDR_W'(1) << sh) - 1;
    return (ADDR_W'(pg) << sh) | ($urandom & low_mask);
  endfunction

  // one access against the page table model; queues the word the block owes
  task automatic predict_access(input logic [ADDR_W-1:0] addr);
    int unsigned n;
    int unsigned pos;
    logic [PAGE_W-1:0] pg;
    access_result_t r;
    bit found;
    n = active_frame_count();
    pg = page_of_address(addr);
    found = 1'b0;
    // lowest matching frame among the ones in use wins
    for (int unsigned i = 0; i < n; i++) begin
      if (!found && model_valid[i] && model_tag[i] == pg) begin
        found = 1'b1;
        model_ref[i] = 1'b1;
        r.hit = 1'b1;
        r.frame = FRAME_W'(i);
        r.faults = model_faults;
      end
    end
    if (!found) begin
      // fault count sticks at all ones
      if (model_faults != '1) model_faults = model_faults + 1;
      // a hand left past the frame count restarts at frame zero
      pos = (model_hand < n) ? model_hand : 0;
      // second chance: clear set bits and move on until a clear one turns up
      while (model_ref[pos]) begin
        model_ref[pos] = 1'b0;
        pos = (pos + 1 < n) ? pos + 1 : 0;
      end
      model_tag[pos] = pg;
      model_valid[pos] = 1'b1;
      model_ref[pos] = 1'b0;
      model_hand = (pos + 1 < n) ? pos + 1 : 0;
      r.hit = 1'b0;
      r.frame = FRAME_W'(pos);
      r.faults = model_faults;
    end
    expected_results.push_back(r);
  endtask

  // everything is sampled at the rising edge: register writes, accepted
  // addresses and accepted result words
  always @(posedge clk) begin : monitor
    access_result_t want;
    if (rst) begin
      for (int i = 0; i < MAX_FRAMES_DEF; i++) begin
        model_tag[i] = '0;
        model_valid[i] = 1'b0;
        model_ref[i] = 1'b0;
      end
      model_hand = 0;
      model_faults = '0;
      cfg_frames = RESET_FRAMES;
      cfg_offset = RESET_OFFSET;
      expected_results.delete();
    end else begin
      if (cfg_write) begin
        reg_writes++;
        if (cfg_index == REG_FRAMES_IN_USE) cfg_frames = cfg_data[FRAMES_W-1:0];
        else if (cfg_index == REG_OFFSET_BITS) cfg_offset = cfg_data[OFFSET_W-1:0];
      end
      if (in_valid && !in_stall) predict_access(address);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: result word with nothing expected: hit=%0b frame=%0d faults=%0d",
                     $realtime, hit, frame_index, fault_total);
        end else begin
          want = expected_results.pop_front();
          if (want.hit) hits_seen++;
          else faults_seen++;
          if (want.hit !== hit || want.frame !== frame_index || want.faults !== fault_total) begin
            failures++;
            if (failures <= 10) begin
              $display("%0t: wrong word: expected hit=%0b frame=%0d faults=%0d",
                       $realtime, want.hit, want.frame, want.faults);
              $display("  got hit=%0b frame=%0d faults=%0d", hit, frame_index, fault_total);
            end
          end
        end
      end
    end
  end

  // offers one address and returns at the falling edge after it is taken,
  // leaving valid high so back-to-back words need no extra edge
  task automatic send_address(input logic [ADDR_W-1:0] addr);
    if (!calm && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_valid <= 1'b1;
    address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // sender goes quiet until every expected word has come back
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // both registers, written back to back while the block is idle
  task automatic set_config(input int unsigned frames, input int unsigned offset);
    wait_for_idle();
    cfg_write <= 1'b1;
    cfg_index <= REG_FRAMES_IN_USE;
    cfg_data <= CFG_W'(frames);
    @(negedge clk);
    cfg_index <= REG_OFFSET_BITS;
    cfg_data <= CFG_W'(offset);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // reset values: all-zero and all-ones addresses, then a hit on page zero
  task automatic test_reset_defaults();
    send_address(32'h0000_0000);
    send_address(32'hFFFF_FFFF);
    send_address(32'h0000_0ABC);
  endtask

  // fill four frames, reference them all, then fault so the hand sweeps
  // every reference bit clear before it picks a victim
  task automatic test_full_sweep();
    set_config(4, 12);
    for (int i = 0; i < 4; i++) send_address({PAGE_W'(20'h00100 + i), 12'h000});
    for (int i = 3; i >= 0; i--) send_address({PAGE_W'(20'h00100 + i), 12'hFFF});
    send_address({20'h00104, 12'h123});
  endtask

  // zero and oversized frame counts, offsets below the minimum and far above it
  task automatic test_register_limits();
    set_config(0, 0);
    send_address(32'h1234_5678);
    send_address(32'h1234_5FFF);
    set_config(127, 31);
    send_address(32'h8000_0000);
    set_config(64, 16);
    send_address(32'hFFFF_0000);
    set_config(1, 17);
    send_address(32'hABCD_0000);
  endtask

  // move the hand past a smaller frame count, shrink, fault, then grow again
  // and hit a page kept in a frame that was out of view
  task automatic test_hand_past_count();
    logic [PAGE_W-1:0] kept;
    int unsigned g;
    set_config(8, 12);
    g = 0;
    do begin
      send_address({PAGE_W'(20'h3A000 + g), 12'h5A5});
      g++;
    end while (model_hand < 5 && g < 10);
    kept = model_tag[model_hand - 1];
    set_config(3, 12);
    send_address({20'h3B000, 12'h000});
    set_config(8, 12);
    send_address({kept, 12'hFFF});
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_output_backpressure();
    set_config(6, 13);
    hold_off <= 1'b1;
    for (int i = 0; i < 6; i++) send_address(address_for_page(PAGE_W'(20'h00777 + i % 3)));
    while (!hold_done) @(negedge clk);
    hold_off <= 1'b0;
    wait_for_idle();
  endtask

  // segments of random traffic, each under its own register setting; most
  // addresses come from a page pool sized near the frame count so hits,
  // long sweeps and evictions all happen, the rest are arbitrary addresses
  task automatic test_random_traffic();
    int unsigned n;
    int unsigned offset;
    int unsigned pool_size;
    for (int seg = 0; seg < 12; seg++) begin
      case ($urandom_range(7))
        0: n = 1;
        1: n = 0;
        2: n = 64;
        3: n = $urandom_range(127, 65);
        default: n = $urandom_range(12, 2);
      endcase
      case ($urandom_range(9))
        0: offset = $urandom_range(11, 0);
        1: offset = $urandom_range(31, 17);
        default: offset = $urandom_range(16, 12);
      endcase
      set_config(n, offset);
      // one segment runs with no idling on either side
      calm <= (seg == 6);
      pool_size = active_frame_count() + $urandom_range(active_frame_count() / 2 + 1, 0);
      // keep part of the old pool so pages left in frames can hit again
      while (page_pool.size() > pool_size / 2)
        page_pool.delete($urandom_range(page_pool.size() - 1));
      while (page_pool.size() < pool_size) page_pool.push_back(PAGE_W'($urandom));
      for (int k = 0; k < 50; k++) begin
        // sender pause mid-stream until everything has drained
        if (seg == 9 && k == 25) wait_for_idle();
        if ($urandom_range(99) < 85)
          send_address(address_for_page(page_pool[$urandom_range(page_pool.size() - 1)]));
        else
          send_address($urandom);
      end
    end
    calm <= 1'b0;
  endtask

  initial begin : run
    int unsigned drain;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_full_sweep();
    test_register_limits();
    test_hand_past_count();
    test_output_backpressure();
    test_random_traffic();

    // drain, then give a worst-case sweep time for stray words
    in_valid <= 1'b0;
    drain = 0;
    while (expected_results.size() != 0 && drain < 20000) begin
      @(negedge clk);
      drain++;
    end
    repeat (80) @(negedge clk);
    if (expected_results.size() != 0) begin
      failures += expected_results.size();
      $display("%0d expected words never came out", expected_results.size());
    end

    $display("checked %0d hits and %0d page faults over %0d register writes",
             hits_seen, faults_seen, reg_writes);
    $display("frame counts 0 to 127, offsets 0 to 31, one long output hold-off, %0d cycles",
             cycle_count);
    if (failures == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
